// ===== hw/rtl/b64e_pkg.sv =====
`timescale 1ns / 1ps

package b64e_pkg;

    // Queue depth between the byte front end and the character back end
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam int unsigned BLOCK_W = 24;
    localparam int unsigned CODE_W  = 6;
    localparam int unsigned NCHAR_W = 3;
    localparam int unsigned IDX_W   = 2;

    // Characters per job
    localparam logic [NCHAR_W-1:0] NCHAR_ONE_BYTE  = 3'd2;
    localparam logic [NCHAR_W-1:0] NCHAR_TWO_BYTES = 3'd3;
    localparam logic [NCHAR_W-1:0] NCHAR_FULL      = 3'd4;

    // Alphabet boundaries and ASCII bases
    localparam logic [CODE_W-1:0] CODE_LOWER_START = 6'd10;
    localparam logic [CODE_W-1:0] CODE_UPPER_START = 6'd36;
    localparam logic [CODE_W-1:0] CODE_DASH        = 6'd62;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_LOWER = 8'h61;
    localparam logic [7:0] ASCII_UPPER = 8'h41;
    localparam logic [7:0] ASCII_DASH  = 8'h2d;
    localparam logic [7:0] ASCII_UNDER = 8'h5f;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_run;
        logic       end_of_message;
    } out_word_t;

    // One flushed group: bits left-aligned, character count, message end flag
    typedef struct packed {
        logic [BLOCK_W-1:0] block;
        logic [NCHAR_W-1:0] nchar;
        logic               last;
    } job_t;

    // Map a 6-bit code onto a URL-safe alphabet: 0-9, a-z, A-Z, dash, underscore
    function automatic logic [7:0] code_to_char(input logic [CODE_W-1:0] code);
        logic [7:0] c8;
        c8 = {2'b00, code};
        if (code < CODE_LOWER_START) begin
            return ASCII_ZERO + c8;
        end else if (code < CODE_UPPER_START) begin
            return ASCII_LOWER + c8 - {2'b00, CODE_LOWER_START};
        end else if (code < CODE_DASH) begin
            return ASCII_UPPER + c8 - {2'b00, CODE_UPPER_START};
        end else if (code == CODE_DASH) begin
            return ASCII_DASH;
        end else begin
            return ASCII_UNDER;
        end
    endfunction

endpackage

// ===== hw/rtl/b64e_front.sv =====
`timescale 1ns / 1ps

module b64e_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  b64e_pkg::in_word_t s_data,
    output logic              job_push,
    output b64e_pkg::job_t    job_data,
    input  logic              job_ready
);
    import b64e_pkg::*;

    logic [15:0] held_reg, held_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        accept;
    logic        flush;

    assign s_ready = job_ready;
    assign accept  = s_valid && s_ready;
    // A third byte or a flagged byte closes the group
    assign flush   = cnt_reg[1] || s_data.last_byte;
    assign job_push = accept && flush;

    // Build the job from held bytes and the incoming one
    always_comb begin
        job_data.last = s_data.last_byte;
        if (cnt_reg[1]) begin
            job_data.block = {held_reg, s_data.data_byte};
            job_data.nchar = NCHAR_FULL;
        end else if (cnt_reg[0]) begin
            job_data.block = {held_reg[7:0], s_data.data_byte, 8'h00};
            job_data.nchar = NCHAR_TWO_BYTES;
        end else begin
            job_data.block = {s_data.data_byte, 16'h0000};
            job_data.nchar = NCHAR_ONE_BYTE;
        end
    end

    // Hold bytes until the group closes, then drop them
    always_comb begin
        held_next = held_reg;
        cnt_next  = cnt_reg;
        if (accept) begin
            if (flush) begin
                held_next = 16'h0000;
                cnt_next  = 2'd0;
            end else begin
                held_next = {held_reg[7:0], s_data.data_byte};
                cnt_next  = cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 16'h0000;
            cnt_reg  <= 2'd0;
        end else begin
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("pending byte count reached three");
`endif

endmodule

// ===== hw/rtl/b64e_queue.sv =====
`timescale 1ns / 1ps

module b64e_queue #(
    parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  b64e_pkg::job_t push_data,
    output logic           push_ready,
    input  logic           pop,
    output b64e_pkg::job_t pop_data,
    output logic           pop_valid
);
    import b64e_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Advance pointers with wrap, track fill
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store pushed jobs
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("queue fill exceeds depth");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");
`endif

endmodule

// ===== hw/rtl/b64e_back.sv =====
`timescale 1ns / 1ps

module b64e_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    input  b64e_pkg::job_t      job_data,
    output logic                job_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output b64e_pkg::out_word_t m_data
);
    import b64e_pkg::*;

    job_t             cur_reg;
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             mv_reg, mv_next;
    out_word_t        md_reg;
    logic             out_adv;
    logic             emit;
    logic             final_char;
    logic [CODE_W-1:0] code;

    assign out_adv    = !mv_reg || m_ready;
    assign emit       = busy_reg && out_adv;
    assign final_char = ({1'b0, idx_reg} == cur_reg.nchar - NCHAR_W'(1));
    // Take the next job when idle or on the last character of the current one
    assign job_pop    = job_valid && (!busy_reg || (emit && final_char));

    // Select the current 6-bit code, most significant first
    always_comb begin
        case (idx_reg)
            2'd0:    code = cur_reg.block[23:18];
            2'd1:    code = cur_reg.block[17:12];
            2'd2:    code = cur_reg.block[11:6];
            default: code = cur_reg.block[5:0];
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        mv_next   = mv_reg;
        if (out_adv) begin
            mv_next = emit;
        end
        if (emit) begin
            idx_next = idx_reg + IDX_W'(1);
            if (final_char) begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
        end
        if (job_pop) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            mv_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            mv_reg   <= mv_next;
        end
    end

    // Load job and output word payloads
    always_ff @(posedge aclk) begin
        if (job_pop) begin
            cur_reg <= job_data;
        end
        if (emit) begin
            md_reg.out_char       <= code_to_char(code);
            md_reg.end_of_run     <= final_char;
            md_reg.end_of_message <= final_char && cur_reg.last;
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> ({1'b0, idx_reg} < cur_reg.nchar))
        else $error("character index past job length");
    a_eom_on_eor: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && md_reg.end_of_message) |-> md_reg.end_of_run)
        else $error("message end without run end");
`endif

endmodule

// ===== hw/rtl/base64_stream_encoder_top.sv =====
`timescale 1ns / 1ps

// Channel  Ports                      Word
// input    s_valid s_ready s_data     in_word_t: data_byte, last_byte
// output   m_valid m_ready m_data     out_word_t: out_char, end_of_run, end_of_message
//
// One character leaves the back end per cycle while m_ready is high; a full
// group of three bytes yields four characters, so the byte rate is set by the
// single character output register. Bytes enter one per cycle while the job
// queue has room. A closing byte's job is queued and then loaded into the
// current-job register ahead of its first character. Reset is synchronous on
// aresetn. A stalled m_ready backs up into the queue and then lowers s_ready.
module base64_stream_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64e_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b64e_pkg::out_word_t m_data
);
    import b64e_pkg::*;

    logic job_push, job_ready, job_pop, job_valid;
    job_t push_job, pop_job;

    b64e_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_push  (job_push),
        .job_data  (push_job),
        .job_ready (job_ready)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_data  (push_job),
        .push_ready (job_ready),
        .pop        (job_pop),
        .pop_data   (pop_job),
        .pop_valid  (job_valid)
    );

    b64e_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_data  (pop_job),
        .job_pop   (job_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== dv/b64e_char_check.sv =====
`timescale 1ns / 1ps

module b64e_char_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  b64e_pkg::in_word_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  b64e_pkg::out_word_t m_data,
    output int                  mismatches,
    output int                  chars_due
);

    import b64e_pkg::*;

    localparam logic [8*64-1:0] URL_ALPHABET =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ-_";
    localparam int PRINT_LIMIT = 40;

    logic [15:0] held_bytes;
    logic [1:0]  held_count;
    out_word_t   char_q[$];

    initial begin
        mismatches = 0;
        chars_due  = 0;
        held_bytes = '0;
        held_count = '0;
    end

    // Leftmost character of the literal sits in the top byte
    function automatic logic [7:0] code_char(input logic [5:0] code);
        return URL_ALPHABET[(63 - int'(code)) * 8 +: 8];
    endfunction

    task automatic report(input string msg);
        if (mismatches < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // Fold one byte into the pending group; queue the characters it flushes
    task automatic encode_byte(input in_word_t w);
        logic [23:0] grp_bits;
        int          nchar;
        out_word_t   c;
        nchar = 0;
        grp_bits = '0;
        if (held_count >= 2) begin
            grp_bits = {held_bytes, w.data_byte};
            nchar = 4;
        end else if (!w.last_byte) begin
            held_bytes = {held_bytes[7:0], w.data_byte};
            held_count = held_count + 2'd1;
        end else if (held_count == 2'd1) begin
            grp_bits = {held_bytes[7:0], w.data_byte, 8'h00};
            nchar = 3;
        end else begin
            grp_bits = {w.data_byte, 16'h0000};
            nchar = 2;
        end
        for (int k = 0; k < nchar; k++) begin
            c.out_char       = code_char(grp_bits[23 - 6*k -: 6]);
            c.end_of_run     = (k == nchar - 1);
            c.end_of_message = (k == nchar - 1) && w.last_byte;
            char_q.push_back(c);
        end
        if (nchar != 0) begin
            held_bytes = '0;
            held_count = '0;
        end
    endtask

    // Compare one delivered character against the oldest expected one
    task automatic check_char(input out_word_t got);
        out_word_t want;
        if (char_q.size() == 0) begin
            report($sformatf("char %h with nothing expected", got.out_char));
            return;
        end
        want = char_q.pop_front();
        if (got.out_char !== want.out_char) begin
            report($sformatf("out_char %h, want %h", got.out_char, want.out_char));
        end
        if (got.end_of_run !== want.end_of_run) begin
            report($sformatf("end_of_run %b, want %b (char %h)",
                             got.end_of_run, want.end_of_run, want.out_char));
        end
        if (got.end_of_message !== want.end_of_message) begin
            report($sformatf("end_of_message %b, want %b (char %h)",
                             got.end_of_message, want.end_of_message, want.out_char));
        end
    endtask

    // Sample both channels at each edge; drop the pending group and expected characters in reset
    always @(posedge aclk) begin
        if (!aresetn) begin
            held_bytes = '0;
            held_count = '0;
            char_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_char(m_data);
            end
            if (s_valid && s_ready) begin
                encode_byte(s_data);
            end
        end
        chars_due <= char_q.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import b64e_pkg::*;

    localparam int HOLD_CYCLES  = 64;
    localparam int PHASE_BYTES  = 100;
    localparam int DRAIN_CYCLES = 12;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    int mismatches;
    int chars_due;
    int send_idle;
    int recv_idle;
    bit hold_pending;

    base64_stream_encoder_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    b64e_char_check u_char_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .chars_due  (chars_due)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Abort a hung run
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Offer one word, idling first at the current rate; hold until accepted
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, last_byte: lst};
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Send random messages until the phase has used up its share of bytes
    task automatic send_random_phase(input int n_bytes);
        int         sent;
        int         len;
        logic [7:0] b;
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 7);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(7) == 0) begin
                    b = $urandom_range(1) ? 8'hff : 8'h00;
                end else begin
                    b = 8'($urandom_range(255));
                end
                send_byte(b, i == len - 1);
            end
            sent += len;
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_pending = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Stimulus and verdict
    initial begin
        send_idle    = 23;
        recv_idle    = 83;
        hold_pending = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // one-byte and two-byte messages at the byte extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        // messages ending exactly on a full group
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
        // full group of dash codes mid-message, then a two-byte tail
        send_byte(8'hfb, 1'b0);
        send_byte(8'hef, 1'b0);
        send_byte(8'hbe, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h80, 1'b1);
        // two full groups, then a one-byte tail
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h0f, 1'b0);
        send_byte(8'hf0, 1'b0);
        send_byte(8'hcc, 1'b0);
        send_byte(8'h01, 1'b1);

        // long receiver hold-off while the sender keeps offering
        hold_pending = 1'b1;
        send_random_phase(PHASE_BYTES);

        send_idle = 83;
        recv_idle = 23;
        send_random_phase(PHASE_BYTES);

        send_idle = 0;
        recv_idle = 0;
        send_random_phase(PHASE_BYTES);

        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (chars_due != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_queue.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder_top.sv
dv/b64e_char_check.sv
dv/testbench.sv
